// ===== rtl/core/ipd_pkg.sv =====
package ipd_pkg;

    // Sequencer states of the controller
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_START,
        S_FILT,
        S_DSTART,
        S_DWAIT,
        S_SUM_PI,
        S_SUM_D,
        S_SUM_RUN,
        S_CLAMP,
        S_DELIVER
    } t_state;

    // Status of one serial multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    // Register indexes on the configuration channel
    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_KP       = t_cfg_idx'(0);
    localparam t_cfg_idx REG_KI       = t_cfg_idx'(1);
    localparam t_cfg_idx REG_KD       = t_cfg_idx'(2);
    localparam t_cfg_idx REG_ALPHA    = t_cfg_idx'(3);
    localparam t_cfg_idx REG_SETPOINT = t_cfg_idx'(4);
    localparam t_cfg_idx REG_DEADBAND = t_cfg_idx'(5);
    localparam t_cfg_idx REG_UPPER    = t_cfg_idx'(6);
    localparam t_cfg_idx REG_LOWER    = t_cfg_idx'(7);

    // Filter factor: Q1.16, 1.0 is the largest effective value
    localparam int              ALPHA_W    = 17;
    localparam int              ALPHA_FRAC = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    // Integer parts of the reset values of gain and setpoint
    localparam int KP_RESET_INT = 10;
    localparam int SP_RESET_INT = 35;

    // Input command codes
    localparam logic CMD_COMPUTE = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

endpackage

// ===== rtl/core/incremental_pid_with_deadband_unit.sv =====
// Velocity-form PID controller with error filter, output limits and deadband.
//
// Channels: a configuration write channel (i_cfg_valid/o_cfg_ready, index and
// data) loads gains, filter factor, setpoint, deadband and limits; it is always
// ready. The user must write it only while the block is idle; the block does
// not enforce this. The input stream carries one sample per beat: tdata holds
// the process value, tuser the command (compute or clear history). The output
// stream returns one result beat per input beat: tdata the control value, tuser
// the limited and deadband flags.
//
// A compute beat's duration is set by the bit-serial multipliers: the error
// filter multiplies 18 bits, then the derivative product runs after it, while
// the proportional and integral products run beside them. A clear beat skips
// the multipliers. A new beat is accepted only after the previous result has
// been loaded into the output register.
//
// Reset clears the loop history, loads the register reset values and empties
// the output register. When the receiver stalls, a finished result waits in
// the output register while the next beat is accepted and worked on; the
// sequencer holds its next result until the output register frees up.
module incremental_pid_with_deadband_unit #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16,
    localparam int TDATA_W      = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int CFG_W        = (VALUE_WIDTH > ipd_pkg::ALPHA_W) ? VALUE_WIDTH
                                                                   : ipd_pkg::ALPHA_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  ipd_pkg::t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [TDATA_W-1:0]        s_axis_tdata,   // [0] up: process_value
    input  logic [0:0]                s_axis_tuser,   // [0]: command
    // output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [TDATA_W-1:0]        m_axis_tdata,   // [0] up: control_output
    output logic [1:0]                m_axis_tuser    // [0]: limited, [1]: in_deadband
);

    localparam int W     = VALUE_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int FA_W  = W + 1;                       // filter multiplicand
    localparam int FB_W  = ipd_pkg::ALPHA_W + 1;        // alpha as signed
    localparam int FP_W  = FA_W + FB_W;
    localparam int PP_W  = 2 * W;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    // ---------------------------------------------------------------
    // Fixed-point helpers
    // ---------------------------------------------------------------
    function automatic logic signed [W+2:0] ext3(input logic signed [W-1:0] v);
        ext3 = {{3{v[W-1]}}, v};
    endfunction

    // Saturate a value with three guard bits to W signed bits
    function automatic logic signed [W-1:0] sat_w(input logic signed [W+2:0] v);
        logic [3:0] top;
        top = v[W+2:W-1];
        if ((&top) || !(|top)) begin
            sat_w = v[W-1:0];
        end else begin
            sat_w = v[W+2] ? VMIN : VMAX;
        end
    endfunction

    // Product shifted right by F with floor, saturated to W bits
    function automatic logic signed [W-1:0] mulq(input logic signed [PP_W-1:0] pr);
        logic [PP_W-F-W:0] upper;
        upper = pr[PP_W-1:F+W-1];
        if ((&upper) || !(|upper)) begin
            mulq = pr[F+W-1:F];
        end else begin
            mulq = pr[PP_W-1] ? VMIN : VMAX;
        end
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [W-1:0]              cfg_kp;
    logic signed [W-1:0]              cfg_ki;
    logic signed [W-1:0]              cfg_kd;
    logic [ipd_pkg::ALPHA_W-1:0]      cfg_alpha;
    logic signed [W-1:0]              cfg_setpoint;
    logic [W-2:0]                     cfg_deadband;
    logic signed [W-1:0]              cfg_upper;
    logic signed [W-1:0]              cfg_lower;

    assign o_cfg_ready = 1'b1;

    ipd_cfg_regs #(
        .VALUE_WIDTH   (W),
        .FRACTION_BITS (F),
        .CFG_W         (CFG_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_kp       (cfg_kp),
        .o_ki       (cfg_ki),
        .o_kd       (cfg_kd),
        .o_alpha    (cfg_alpha),
        .o_setpoint (cfg_setpoint),
        .o_deadband (cfg_deadband),
        .o_upper    (cfg_upper),
        .o_lower    (cfg_lower)
    );

    // ---------------------------------------------------------------
    // State and datapath registers
    // ---------------------------------------------------------------
    ipd_pkg::t_state        r_state;
    ipd_pkg::t_state        n_state;

    logic                   r_cmd;
    logic signed [W-1:0]    r_pv;
    logic signed [W-1:0]    r_err;
    logic signed [W-1:0]    r_filt;
    logic signed [W-1:0]    r_sum;

    // loop history
    logic signed [W-1:0]    r_prev_err;
    logic signed [W-1:0]    r_prev_filt;
    logic signed [W-1:0]    r_older_filt;
    logic signed [W-1:0]    r_running;

    // staged result, then output register
    logic [W-1:0]           r_res_data;
    logic                   r_res_lim;
    logic                   r_res_band;
    logic                   r_out_valid;
    logic [W-1:0]           r_out_data;
    logic                   r_out_lim;
    logic                   r_out_band;

    // ---------------------------------------------------------------
    // Serial multipliers: filter, proportional, integral, derivative
    // ---------------------------------------------------------------
    logic                      start_fpi;
    logic                      start_d;
    logic signed [FA_W-1:0]    filt_a;
    logic signed [FB_W-1:0]    filt_b;
    logic signed [FP_W-1:0]    filt_prod;
    logic signed [W-1:0]       p_b;
    logic signed [W-1:0]       d_b;
    logic signed [PP_W-1:0]    p_prod;
    logic signed [PP_W-1:0]    i_prod;
    logic signed [PP_W-1:0]    d_prod;
    ipd_pkg::t_mul_stat        filt_stat;
    ipd_pkg::t_mul_stat        p_stat;
    ipd_pkg::t_mul_stat        i_stat;
    ipd_pkg::t_mul_stat        d_stat;

    // filt = last + floor(alpha * (err - last) / 2^16)
    assign filt_a = {r_err[W-1], r_err} - {r_prev_filt[W-1], r_prev_filt};
    assign filt_b = {1'b0, cfg_alpha};
    assign p_b    = sat_w(ext3(r_err) - ext3(r_prev_err));
    assign d_b    = sat_w(ext3(r_filt) - (ext3(r_prev_filt) <<< 1) + ext3(r_older_filt));

    ipd_serial_mul #(.A_W(FA_W), .B_W(FB_W)) u_mul_filt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_fpi),
        .i_a       (filt_a),
        .i_b       (filt_b),
        .o_stat    (filt_stat),
        .o_product (filt_prod)
    );

    ipd_serial_mul #(.A_W(W), .B_W(W)) u_mul_p (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_fpi),
        .i_a       (cfg_kp),
        .i_b       (p_b),
        .o_stat    (p_stat),
        .o_product (p_prod)
    );

    ipd_serial_mul #(.A_W(W), .B_W(W)) u_mul_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_fpi),
        .i_a       (cfg_ki),
        .i_b       (r_err),
        .o_stat    (i_stat),
        .o_product (i_prod)
    );

    ipd_serial_mul #(.A_W(W), .B_W(W)) u_mul_d (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_d),
        .i_a       (cfg_kd),
        .i_b       (d_b),
        .o_stat    (d_stat),
        .o_product (d_prod)
    );

    // ---------------------------------------------------------------
    // Combinational values used by the sequencer steps
    // ---------------------------------------------------------------
    logic signed [W+2:0]    filt_shift;
    logic signed [W-1:0]    filt_new;
    logic signed [W-1:0]    q_p;
    logic signed [W-1:0]    q_i;
    logic signed [W-1:0]    q_d;
    logic [W-1:0]           err_mag;
    logic                   band_hit;
    logic                   over_upper;
    logic                   under_lower;
    logic signed [W-1:0]    clamped;

    always_comb begin
        filt_shift  = filt_prod[FP_W-1:ipd_pkg::ALPHA_FRAC];
        filt_new    = W'(filt_shift + ext3(r_prev_filt));
        q_p         = mulq(p_prod);
        q_i         = mulq(i_prod);
        q_d         = mulq(d_prod);
        // the most negative error maps to its magnitude as an unsigned word
        err_mag     = r_err[W-1] ? W'(-r_err) : W'(r_err);
        band_hit    = (err_mag < {1'b0, cfg_deadband});
        // test the upper limit first so crossed limits resolve to upper
        over_upper  = (r_sum > cfg_upper);
        under_lower = (r_sum < cfg_lower);
        if (over_upper) begin
            clamped = cfg_upper;
        end else if (under_lower) begin
            clamped = cfg_lower;
        end else begin
            clamped = r_sum;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipd_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ipd_pkg::S_ERR;
                end
            end
            ipd_pkg::S_ERR: begin
                n_state = (r_cmd == ipd_pkg::CMD_CLEAR) ? ipd_pkg::S_DELIVER
                                                        : ipd_pkg::S_START;
            end
            ipd_pkg::S_START:   n_state = ipd_pkg::S_FILT;
            ipd_pkg::S_FILT: begin
                if (filt_stat.done) begin
                    n_state = ipd_pkg::S_DSTART;
                end
            end
            ipd_pkg::S_DSTART:  n_state = ipd_pkg::S_DWAIT;
            ipd_pkg::S_DWAIT: begin
                if (d_stat.done) begin
                    n_state = ipd_pkg::S_SUM_PI;
                end
            end
            ipd_pkg::S_SUM_PI:  n_state = ipd_pkg::S_SUM_D;
            ipd_pkg::S_SUM_D:   n_state = ipd_pkg::S_SUM_RUN;
            ipd_pkg::S_SUM_RUN: n_state = ipd_pkg::S_CLAMP;
            ipd_pkg::S_CLAMP:   n_state = ipd_pkg::S_DELIVER;
            ipd_pkg::S_DELIVER: begin
                if (out_free) begin
                    n_state = ipd_pkg::S_IDLE;
                end
            end
            default:            n_state = ipd_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    logic load_out;

    always_comb begin
        s_axis_tready = 1'b0;
        start_fpi     = 1'b0;
        start_d       = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ipd_pkg::S_IDLE:    s_axis_tready = 1'b1;
            ipd_pkg::S_START:   start_fpi     = 1'b1;
            ipd_pkg::S_DSTART:  start_d       = 1'b1;
            ipd_pkg::S_DELIVER: load_out      = out_free;
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ipd_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_prev_err   <= '0;
            r_prev_filt  <= '0;
            r_older_filt <= '0;
            r_running    <= '0;
        end else begin
            r_state <= n_state;

            // hold a waiting result until the receiver takes it
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ipd_pkg::S_ERR && r_cmd == ipd_pkg::CMD_CLEAR) begin
                r_prev_err   <= '0;
                r_prev_filt  <= '0;
                r_older_filt <= '0;
                r_running    <= '0;
            end else if (r_state == ipd_pkg::S_CLAMP) begin
                // running value advances even inside the deadband
                r_running    <= clamped;
                r_prev_err   <= r_err;
                r_older_filt <= r_prev_filt;
                r_prev_filt  <= r_filt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= s_axis_tuser[0];
            r_pv  <= s_axis_tdata[W-1:0];
        end

        unique case (r_state)
            ipd_pkg::S_ERR: begin
                r_err      <= sat_w(ext3(cfg_setpoint) - ext3(r_pv));
                r_res_data <= '0;
                r_res_lim  <= 1'b0;
                r_res_band <= 1'b0;
            end
            ipd_pkg::S_FILT: begin
                if (filt_stat.done) begin
                    r_filt <= filt_new;
                end
            end
            ipd_pkg::S_SUM_PI:  r_sum <= sat_w(ext3(q_p) + ext3(q_i));
            ipd_pkg::S_SUM_D:   r_sum <= sat_w(ext3(r_sum) + ext3(q_d));
            ipd_pkg::S_SUM_RUN: r_sum <= sat_w(ext3(r_sum) + ext3(r_running));
            ipd_pkg::S_CLAMP: begin
                r_res_data <= band_hit ? '0 : clamped;
                r_res_lim  <= over_upper || under_lower;
                r_res_band <= band_hit;
            end
            default: begin
            end
        endcase

        if (load_out) begin
            r_out_data <= r_res_data;
            r_out_lim  <= r_res_lim;
            r_out_band <= r_res_band;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = TDATA_W'(r_out_data);
    assign m_axis_tuser[0] = r_out_lim;
    assign m_axis_tuser[1] = r_out_band;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_one_beat_per_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice without finishing a sample");

    a_result_from_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(r_state) == ipd_pkg::S_DELIVER)
        else $error("result appeared outside the deliver step");

    a_filter_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        filt_stat.done |-> r_state == ipd_pkg::S_FILT && !p_stat.done && !i_stat.done)
        else $error("filter product finished out of sequence");

    a_deriv_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_stat.done |-> r_state == ipd_pkg::S_DWAIT && !p_stat.busy && !i_stat.busy)
        else $error("derivative product finished before the other terms");

    a_band_zero_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
        else $error("nonzero drive reported inside the deadband");

endmodule

// ===== rtl/core/ipd_serial_mul.sv =====
module ipd_serial_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [A_W-1:0]       i_a,
    input  logic signed [B_W-1:0]       i_b,
    output ipd_pkg::t_mul_stat          o_stat,
    output logic signed [A_W+B_W-1:0]   o_product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [P_W-1:0]      r_mcand;
    logic [B_W-1:0]      r_mplier;
    logic [P_W-1:0]      r_acc;

    logic                last_bit;
    logic [P_W-1:0]      addend;

    // The sign bit of the multiplier carries negative weight: subtract on it
    always_comb begin
        last_bit = (r_cnt == CNT_W'(B_W - 1));
        addend   = last_bit ? (~r_mcand + P_W'(1)) : r_mcand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (last_bit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One multiplier bit per cycle, least significant first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= P_W'(i_a);
            r_mplier <= i_b;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + addend;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;

endmodule

// ===== rtl/core/ipd_cfg_regs.sv =====
module ipd_cfg_regs #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16,
    parameter int CFG_W         = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_valid,
    input  ipd_pkg::t_cfg_idx                    i_wr_index,
    input  logic [CFG_W-1:0]                     i_wr_data,
    output logic signed [VALUE_WIDTH-1:0]        o_kp,
    output logic signed [VALUE_WIDTH-1:0]        o_ki,
    output logic signed [VALUE_WIDTH-1:0]        o_kd,
    output logic [ipd_pkg::ALPHA_W-1:0]          o_alpha,
    output logic signed [VALUE_WIDTH-1:0]        o_setpoint,
    output logic [VALUE_WIDTH-2:0]               o_deadband,
    output logic signed [VALUE_WIDTH-1:0]        o_upper,
    output logic signed [VALUE_WIDTH-1:0]        o_lower
);

    localparam int W = VALUE_WIDTH;

    logic signed [W-1:0]              r_kp;
    logic signed [W-1:0]              r_ki;
    logic signed [W-1:0]              r_kd;
    logic [ipd_pkg::ALPHA_W-1:0]      r_alpha;
    logic signed [W-1:0]              r_setpoint;
    logic [W-2:0]                     r_deadband;
    logic signed [W-1:0]              r_upper;
    logic signed [W-1:0]              r_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= W'(ipd_pkg::KP_RESET_INT) << FRACTION_BITS;
            r_ki       <= '0;
            r_kd       <= '0;
            r_alpha    <= ipd_pkg::ALPHA_ONE;
            r_setpoint <= W'(ipd_pkg::SP_RESET_INT) << FRACTION_BITS;
            r_deadband <= '0;
            r_upper    <= '0;
            r_lower    <= '0;
        end else if (i_wr_valid) begin
            unique case (i_wr_index)
                ipd_pkg::REG_KP:       r_kp       <= i_wr_data[W-1:0];
                ipd_pkg::REG_KI:       r_ki       <= i_wr_data[W-1:0];
                ipd_pkg::REG_KD:       r_kd       <= i_wr_data[W-1:0];
                ipd_pkg::REG_ALPHA:    r_alpha    <= i_wr_data[ipd_pkg::ALPHA_W-1:0];
                ipd_pkg::REG_SETPOINT: r_setpoint <= i_wr_data[W-1:0];
                ipd_pkg::REG_DEADBAND: r_deadband <= i_wr_data[W-2:0];
                ipd_pkg::REG_UPPER:    r_upper    <= i_wr_data[W-1:0];
                ipd_pkg::REG_LOWER:    r_lower    <= i_wr_data[W-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Factors above one act as one
    assign o_alpha    = (r_alpha > ipd_pkg::ALPHA_ONE) ? ipd_pkg::ALPHA_ONE : r_alpha;
    assign o_kp       = r_kp;
    assign o_ki       = r_ki;
    assign o_kd       = r_kd;
    assign o_setpoint = r_setpoint;
    assign o_deadband = r_deadband;
    assign o_upper    = r_upper;
    assign o_lower    = r_lower;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int VW = 32;
    localparam int FB = 16;

    typedef logic signed [VW-1:0] t_q;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam t_q Q_ONE = t_q'(1) <<< FB;
    localparam t_q Q_TOP = 32'h7FFF_FFFF;
    localparam t_q Q_BOTTOM = 32'h8000_0000;

    // Register indexes past the last real register: the block must ignore them
    localparam ipd_pkg::t_cfg_idx IDX_UNUSED_FIRST =
        ipd_pkg::t_cfg_idx'(ipd_pkg::REG_LOWER + 1);
    localparam ipd_pkg::t_cfg_idx IDX_UNUSED_LAST = '1;

    localparam int RAND_PHASES = 14;
    localparam int RAND_ITEMS = 32;
    localparam int HOLD_PHASE = 3;
    localparam int QUIET_FROM = 11;
    localparam int LONG_HOLD = 600;
    // Idle time at the end of the run, before the verdict
    localparam int TAIL_CYCLES = 4 * (VW + 29);
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic cmd;
        t_q   pv;
    } t_sample;

    typedef struct packed {
        t_q   ctl;
        logic limited;
        logic in_band;
    } t_ctl_result;

    // DUT signals, all inputs known from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    ipd_pkg::t_cfg_idx i_cfg_index = '0;
    logic [31:0]       i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // [31:0]: process_value
    logic [0:0]        s_axis_tuser = '0;   // [0]: command
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // [31:0]: control_output
    logic [1:0]        m_axis_tuser;        // [0]: limited, [1]: in_deadband

    // Mirror of the configuration registers, loaded with their reset values
    t_q          gain_p = ipd_pkg::KP_RESET_INT * Q_ONE;
    t_q          coef_i = '0;
    t_q          coef_d = '0;
    logic [16:0] alpha_f = ipd_pkg::ALPHA_ONE;
    t_q          setpoint_q = ipd_pkg::SP_RESET_INT * Q_ONE;
    logic [30:0] deadband_q = '0;
    t_q          limit_hi = '0;
    t_q          limit_lo = '0;

    // Loop history kept by the predictor
    t_q err_last = '0;
    t_q filt_last = '0;
    t_q filt_older = '0;
    t_q run_ctl = '0;

    t_sample     sample_q[$];
    t_ctl_result ctl_expect_q[$];
    t_sample     drv_item;
    t_ctl_result want;

    // Idle controls: percent chance of starting a burst on each side
    int          src_pct = 0;
    int          snk_pct = 0;
    int          src_gap = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          fail_cnt = 0;
    int unsigned wd_cycles;

    incremental_pid_with_deadband_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_q sat_q(longint v);
        if (v > Q_MAX) return t_q'(Q_MAX);
        if (v < Q_MIN) return t_q'(Q_MIN);
        return t_q'(v);
    endfunction

    // Fixed-point product: exact, floor of the shift, then saturate
    function automatic t_q scale_q(longint coef, longint val);
        longint prod;
        prod = coef * val;
        return sat_q(prod >>> FB);
    endfunction

    // Advance the loop by one sample and return the beat the block must send
    function automatic t_ctl_result next_control(logic cmd, t_q pv);
        t_ctl_result res;
        longint e, a, f, p, i, d, s, mag;
        res = '0;
        if (cmd == ipd_pkg::CMD_CLEAR) begin
            err_last = '0;
            filt_last = '0;
            filt_older = '0;
            run_ctl = '0;
            return res;
        end
        e = sat_q(longint'(setpoint_q) - longint'(pv));
        // Filter factors above one act as one
        a = (alpha_f > ipd_pkg::ALPHA_ONE) ? longint'(ipd_pkg::ALPHA_ONE)
                                           : longint'(alpha_f);
        f = (a * e + (longint'(ipd_pkg::ALPHA_ONE) - a) * longint'(filt_last)) >>> FB;
        p = scale_q(gain_p, sat_q(e - longint'(err_last)));
        i = scale_q(coef_i, e);
        d = scale_q(coef_d, sat_q(f - 2 * longint'(filt_last) + longint'(filt_older)));
        s = sat_q(p + i);
        s = sat_q(s + d);
        s = sat_q(s + longint'(run_ctl));
        // Upper limit wins when the limits cross
        if (s > longint'(limit_hi)) begin
            s = limit_hi;
            res.limited = 1'b1;
        end else if (s < longint'(limit_lo)) begin
            s = limit_lo;
            res.limited = 1'b1;
        end
        run_ctl = t_q'(s);
        mag = (e < 0) ? -e : e;
        // Inside the deadband the output reads zero but the running value still moves
        res.in_band = (mag < longint'(deadband_q));
        res.ctl = res.in_band ? '0 : run_ctl;
        err_last = t_q'(e);
        filt_older = filt_last;
        filt_last = t_q'(f);
        return res;
    endfunction

    // Write one register; call at a rising edge, returns at the accepting edge
    task automatic cfg_write(ipd_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ipd_pkg::REG_KP:       gain_p = data;
            ipd_pkg::REG_KI:       coef_i = data;
            ipd_pkg::REG_KD:       coef_d = data;
            ipd_pkg::REG_ALPHA:    alpha_f = data[16:0];
            ipd_pkg::REG_SETPOINT: setpoint_q = data;
            ipd_pkg::REG_DEADBAND: deadband_q = data[30:0];
            ipd_pkg::REG_UPPER:    limit_hi = data;
            ipd_pkg::REG_LOWER:    limit_lo = data;
            default: ;
        endcase
    endtask

    // Hold until every sample is in and every result is checked; ends on a rising edge
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || ctl_expect_q.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic push_sample(logic cmd, t_q pv);
        sample_q.push_back(t_sample'{cmd, pv});
    endtask

    // Mostly modest Q16.16 values, sometimes the extremes or anything at all
    function automatic t_q pick_word(int span_log2);
        t_q w;
        case ($urandom_range(0, 9))
            0: w = Q_TOP;
            1: w = Q_BOTTOM;
            2: w = '0;
            3: w = $urandom;
            default: begin
                w = $urandom_range(0, 1 << span_log2);
                if ($urandom_range(0, 1) != 0) w = -w;
            end
        endcase
        return w;
    endfunction

    // Driver: present pending samples, predict each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                ctl_expect_q.push_back(next_control(s_axis_tuser[0], s_axis_tdata));
            // Keep a pending beat on the bus until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0 && src_pct != 0
                             && $urandom_range(0, 99) < src_pct) begin
                    src_gap <= $urandom_range(0, 18);
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    drv_item = sample_q.pop_front();
                    s_axis_tdata <= drv_item.pv;
                    s_axis_tuser <= drv_item.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction, drive backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (ctl_expect_q.size() == 0) begin
                    $error("result beat with nothing expected: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    fail_cnt++;
                end else begin
                    want = ctl_expect_q.pop_front();
                    if (m_axis_tdata !== want.ctl) begin
                        $error("control_output: expected %0d, actual %0d",
                               want.ctl, $signed(m_axis_tdata));
                        fail_cnt++;
                    end
                    if (m_axis_tuser[0] !== want.limited) begin
                        $error("limited: expected %b, actual %b",
                               want.limited, m_axis_tuser[0]);
                        fail_cnt++;
                    end
                    if (m_axis_tuser[1] !== want.in_band) begin
                        $error("in_deadband: expected %b, actual %b",
                               want.in_band, m_axis_tuser[1]);
                        fail_cnt++;
                    end
                end
            end
            // A new hold request starts a long stretch with ready low
            if (hold_token != hold_seen) begin
                hold_seen <= hold_token;
                hold_left <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (snk_pct != 0 && $urandom_range(0, 99) < snk_pct) begin
                stall_left <= $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end a hung run
    initial begin
        for (wd_cycles = 0; wd_cycles < CYCLE_LIMIT; wd_cycles++)
            @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_q hi, lo, lim_a, lim_b, ofs, pv;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: both limits at zero pin the running value
        @(negedge i_clk);
        src_pct = 20;
        snk_pct = 20;
        push_sample(ipd_pkg::CMD_COMPUTE, '0);
        push_sample(ipd_pkg::CMD_COMPUTE, ipd_pkg::SP_RESET_INT * Q_ONE);
        push_sample(ipd_pkg::CMD_COMPUTE, Q_TOP);
        push_sample(ipd_pkg::CMD_COMPUTE, Q_BOTTOM);
        push_sample(ipd_pkg::CMD_CLEAR, Q_TOP);
        wait_drained();

        // Plain gains, widest limits; error saturation at the extremes, clear in between
        cfg_write(ipd_pkg::REG_KP, Q_ONE);
        cfg_write(ipd_pkg::REG_KI, Q_ONE / 2);
        cfg_write(ipd_pkg::REG_KD, Q_ONE / 4);
        cfg_write(ipd_pkg::REG_ALPHA, 17'h08000);
        cfg_write(ipd_pkg::REG_SETPOINT, '0);
        cfg_write(ipd_pkg::REG_DEADBAND, '0);
        cfg_write(ipd_pkg::REG_UPPER, Q_TOP);
        cfg_write(ipd_pkg::REG_LOWER, Q_BOTTOM);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        push_sample(ipd_pkg::CMD_COMPUTE, -Q_ONE);
        push_sample(ipd_pkg::CMD_COMPUTE, -2 * Q_ONE);
        push_sample(ipd_pkg::CMD_COMPUTE, Q_TOP);
        push_sample(ipd_pkg::CMD_COMPUTE, Q_BOTTOM);
        push_sample(ipd_pkg::CMD_COMPUTE, '0);
        push_sample(ipd_pkg::CMD_CLEAR, '0);
        push_sample(ipd_pkg::CMD_COMPUTE, 3 * Q_ONE);
        wait_drained();

        // Extreme registers: filter factor above one, widest deadband, crossed
        // limits at the rails, and writes to indexes that do not exist
        cfg_write(IDX_UNUSED_FIRST, $urandom);
        cfg_write(ipd_pkg::REG_KP, Q_TOP);
        cfg_write(ipd_pkg::REG_KI, Q_BOTTOM);
        cfg_write(ipd_pkg::REG_KD, Q_TOP);
        cfg_write(ipd_pkg::REG_ALPHA, 17'h1FFFF);
        cfg_write(ipd_pkg::REG_SETPOINT, Q_TOP);
        cfg_write(ipd_pkg::REG_DEADBAND, 31'h7FFF_FFFF);
        cfg_write(ipd_pkg::REG_UPPER, Q_BOTTOM);
        cfg_write(ipd_pkg::REG_LOWER, Q_TOP);
        cfg_write(IDX_UNUSED_LAST, $urandom);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        push_sample(ipd_pkg::CMD_COMPUTE, Q_BOTTOM);
        push_sample(ipd_pkg::CMD_COMPUTE, Q_TOP);
        push_sample(ipd_pkg::CMD_COMPUTE, '0);
        push_sample(ipd_pkg::CMD_COMPUTE, 12345);
        wait_drained();

        // Crossed limits near zero, frozen filter, deadband edges
        cfg_write(ipd_pkg::REG_KP, Q_ONE);
        cfg_write(ipd_pkg::REG_KI, Q_ONE);
        cfg_write(ipd_pkg::REG_KD, '0);
        cfg_write(ipd_pkg::REG_ALPHA, '0);
        cfg_write(ipd_pkg::REG_SETPOINT, '0);
        cfg_write(ipd_pkg::REG_DEADBAND, 2 * Q_ONE);
        cfg_write(ipd_pkg::REG_UPPER, -Q_ONE);
        cfg_write(ipd_pkg::REG_LOWER, Q_ONE);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        push_sample(ipd_pkg::CMD_COMPUTE, -5 * Q_ONE);
        push_sample(ipd_pkg::CMD_COMPUTE, 5 * Q_ONE);
        push_sample(ipd_pkg::CMD_COMPUTE, Q_ONE);
        push_sample(ipd_pkg::CMD_COMPUTE, -2 * Q_ONE);
        push_sample(ipd_pkg::CMD_COMPUTE, -(2 * Q_ONE - 1));
        push_sample(ipd_pkg::CMD_CLEAR, -Q_ONE);
        wait_drained();

        // Random phases: fresh registers each time, samples mostly near the setpoint
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            cfg_write(ipd_pkg::REG_KP, pick_word(18));
            cfg_write(ipd_pkg::REG_KI, pick_word(16));
            cfg_write(ipd_pkg::REG_KD, pick_word(18));
            case ($urandom_range(0, 5))
                0: cfg_write(ipd_pkg::REG_ALPHA, '0);
                1: cfg_write(ipd_pkg::REG_ALPHA, ipd_pkg::ALPHA_ONE);
                2: cfg_write(ipd_pkg::REG_ALPHA, $urandom_range(65537, 131071));
                default: cfg_write(ipd_pkg::REG_ALPHA, $urandom_range(0, 65536));
            endcase
            cfg_write(ipd_pkg::REG_SETPOINT, pick_word(24));
            case ($urandom_range(0, 5))
                0, 1: cfg_write(ipd_pkg::REG_DEADBAND, '0);
                2: cfg_write(ipd_pkg::REG_DEADBAND, 31'h7FFF_FFFF);
                default: cfg_write(ipd_pkg::REG_DEADBAND, $urandom_range(0, 1 << 17));
            endcase
            lim_a = $urandom_range(0, 1 << 24);
            lim_b = -$urandom_range(0, 1 << 24);
            case ($urandom_range(0, 9))
                0: begin hi = Q_TOP; lo = Q_BOTTOM; end
                1: begin hi = lim_b; lo = lim_a; end
                2: begin hi = pick_word(24); lo = pick_word(24); end
                default: begin hi = lim_a; lo = lim_b; end
            endcase
            cfg_write(ipd_pkg::REG_UPPER, hi);
            cfg_write(ipd_pkg::REG_LOWER, lo);
            if ($urandom_range(0, 3) == 0)
                cfg_write(ipd_pkg::t_cfg_idx'($urandom_range(IDX_UNUSED_FIRST,
                                                             IDX_UNUSED_LAST)),
                          $urandom);
            i_cfg_valid <= 1'b0;
            // Stall the receiver long enough for the block to back up into its input
            if (ph == HOLD_PHASE)
                hold_token <= hold_token + 1;
            @(negedge i_clk);
            if (ph >= QUIET_FROM) begin
                src_pct = 0;
                snk_pct = 0;
            end else begin
                n = $urandom_range(0, 3);
                src_pct = (n == 0) ? 0 : 15 * n;
                n = $urandom_range(0, 3);
                snk_pct = (n == 0) ? 0 : 15 * n;
            end
            for (int k = 0; k < RAND_ITEMS; k++) begin
                ofs = $urandom_range(0, 1 << $urandom_range(0, 20));
                if ($urandom_range(0, 1) != 0) ofs = -ofs;
                pv = setpoint_q + ofs;
                case ($urandom_range(0, 19))
                    0: push_sample(ipd_pkg::CMD_CLEAR, $urandom);
                    1, 2: push_sample(ipd_pkg::CMD_COMPUTE, $urandom);
                    3: push_sample(ipd_pkg::CMD_COMPUTE,
                                   ($urandom_range(0, 1) != 0) ? Q_TOP : Q_BOTTOM);
                    4: push_sample(ipd_pkg::CMD_COMPUTE, setpoint_q - t_q'(deadband_q));
                    5: push_sample(ipd_pkg::CMD_COMPUTE,
                                   setpoint_q - t_q'(deadband_q) + 1);
                    default: push_sample(ipd_pkg::CMD_COMPUTE, pv);
                endcase
            end
            wait_drained();
        end

        // Let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
